// ===== design/pls_pkg.sv =====
`default_nettype none

package pls_pkg;

  // Line store geometry
  localparam int LINE_WIDTH = 128;
  localparam int PIXEL_BITS = 8;
  localparam int INDEX_BITS = $clog2(LINE_WIDTH);

  // Quotient has one bit per doubling of the line width
  localparam int QUOT_BITS  = INDEX_BITS;
  localparam int COUNT_BITS = $clog2(QUOT_BITS);

  // Column and span widths
  localparam int X_BITS    = 9;
  localparam int EDGE_BITS = 8;

  // Right end of the span sits this far above the right edge byte
  localparam logic [X_BITS:0] SPAN_BASE = 10'h100;

  // Action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic write;    // store a source pen
    logic capture;  // latch fetch operands
    logic step;     // one divider iteration
    logic read;     // registered line store read
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_range; // fetch column lies in the span
    logic last;     // final divider iteration this cycle
  } status_t;

endpackage

`default_nettype wire

// ===== design/pls_datapath.sv =====
`default_nettype none

module pls_datapath (
  input  wire logic                                clk,
  input  wire pls_pkg::cmd_t                       cmd,
  output pls_pkg::status_t                         status,
  input  wire logic [pls_pkg::INDEX_BITS-1:0]      src_index,
  input  wire logic [pls_pkg::PIXEL_BITS-1:0]      src_value,
  input  wire logic [pls_pkg::X_BITS-1:0]          dest_x,
  input  wire logic [pls_pkg::EDGE_BITS-1:0]       left_edge,
  input  wire logic [pls_pkg::EDGE_BITS-1:0]       right_edge,
  output logic      [pls_pkg::PIXEL_BITS-1:0]      pixel,
  output logic                                     inside_res,
  output logic      [pls_pkg::QUOT_BITS-1:0]       source_pos
);

  logic [pls_pkg::PIXEL_BITS-1:0] line_store [pls_pkg::LINE_WIDTH];
  logic [pls_pkg::PIXEL_BITS-1:0] rd_data;

  logic [pls_pkg::X_BITS-1:0]     rem;
  logic [pls_pkg::X_BITS-1:0]     span;
  logic [pls_pkg::QUOT_BITS-1:0]  quot;
  logic [pls_pkg::COUNT_BITS-1:0] cnt;
  logic                           inside_r;

  logic [pls_pkg::X_BITS:0]       right_end;
  logic [pls_pkg::X_BITS:0]       span_wide;
  logic [pls_pkg::X_BITS-1:0]     diff;
  logic [pls_pkg::X_BITS:0]       rem_sh;
  logic [pls_pkg::X_BITS:0]       rem_sub;
  logic                           fits;

  // Span bounds and membership
  always_comb begin
    right_end = pls_pkg::SPAN_BASE + {2'b00, right_edge};
    span_wide = right_end - {2'b00, left_edge};
    diff      = dest_x - {1'b0, left_edge};
    status.in_range = ({1'b0, dest_x} >= {2'b00, left_edge}) &&
                      ({1'b0, dest_x} < right_end);
    status.last     = cmd.step &&
                      (cnt == pls_pkg::COUNT_BITS'(pls_pkg::QUOT_BITS - 1));
  end

  // Restoring divide step: offset < span, so each step yields one quotient bit
  always_comb begin
    rem_sh  = {rem, 1'b0};
    fits    = rem_sh >= {1'b0, span};
    rem_sub = rem_sh - {1'b0, span};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rem      <= diff;
      span     <= span_wide[pls_pkg::X_BITS-1:0];
      quot     <= '0;
      cnt      <= '0;
      inside_r <= status.in_range;
    end else if (cmd.step) begin
      rem  <= fits ? rem_sub[pls_pkg::X_BITS-1:0] : rem_sh[pls_pkg::X_BITS-1:0];
      quot <= {quot[pls_pkg::QUOT_BITS-2:0], fits};
      cnt  <= cnt + 1'b1;
    end
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      line_store[src_index] <= src_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data <= line_store[quot];
    end
  end

  // Background pen outside the span
  always_comb begin
    inside_res = inside_r;
    pixel      = inside_r ? rd_data : '0;
    source_pos = inside_r ? quot : '0;
  end

endmodule

`default_nettype wire

// ===== design/pls_ctrl.sv =====
`default_nettype none

module pls_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             action,
  input  wire pls_pkg::status_t status,
  output pls_pkg::cmd_t         cmd,
  output logic                  busy,
  output logic                  done
);

  pls_pkg::state_t state;
  pls_pkg::state_t state_next;
  logic            accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pls_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pls_pkg::ST_IDLE, pls_pkg::ST_DONE: begin
        if (start && action == pls_pkg::ACT_FETCH) begin
          state_next = status.in_range ? pls_pkg::ST_DIVIDE : pls_pkg::ST_DONE;
        end else begin
          state_next = pls_pkg::ST_IDLE;
        end
      end
      pls_pkg::ST_DIVIDE: begin
        if (status.last) begin
          state_next = pls_pkg::ST_READ;
        end
      end
      pls_pkg::ST_READ: begin
        state_next = pls_pkg::ST_DONE;
      end
      default: begin
        state_next = pls_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    busy        = (state == pls_pkg::ST_DIVIDE) || (state == pls_pkg::ST_READ);
    done        = state == pls_pkg::ST_DONE;
    cmd.write   = accept && action == pls_pkg::ACT_LOAD;
    cmd.capture = accept && action == pls_pkg::ACT_FETCH;
    cmd.step    = state == pls_pkg::ST_DIVIDE;
    cmd.read    = state == pls_pkg::ST_READ;
  end

endmodule

`default_nettype wire

// ===== design/perspective_line_scaler_unit.sv =====
// Sequence: a load transaction writes the line store at its accept edge, no result.
// A fetch outside the span strobes its result in the cycle after accept; one inside
// the span runs ST_DIVIDE (one quotient bit per cycle), ST_READ, then ST_DONE.
// Throughput: loads and outside fetches 1 per cycle when not busy; inside fetches hold
// busy through divide and read. The receiver cannot stall; done marks a result.
// Reset (rst, synchronous) returns the controller to idle; the line store is not cleared.
`default_nettype none

module perspective_line_scaler_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  output logic                                     done,
  input  wire logic                                action,
  input  wire logic [pls_pkg::INDEX_BITS-1:0]      src_index,
  input  wire logic [pls_pkg::PIXEL_BITS-1:0]      src_value,
  input  wire logic [pls_pkg::X_BITS-1:0]          dest_x,
  input  wire logic [pls_pkg::EDGE_BITS-1:0]       left_edge,
  input  wire logic [pls_pkg::EDGE_BITS-1:0]       right_edge,
  output logic      [pls_pkg::PIXEL_BITS-1:0]      pixel,
  output logic                                     inside_res,
  output logic      [pls_pkg::QUOT_BITS-1:0]       source_pos
);

  pls_pkg::cmd_t    cmd;
  pls_pkg::status_t status;

  pls_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  pls_datapath u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .src_index  (src_index),
    .src_value  (src_value),
    .dest_x     (dest_x),
    .left_edge  (left_edge),
    .right_edge (right_edge),
    .pixel      (pixel),
    .inside_res (inside_res),
    .source_pos (source_pos)
  );

  // Fetch outside the span answers next cycle with background
  a_outside_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == pls_pkg::ACT_FETCH && !status.in_range)
      |=> (done && !inside_res))
    else $error("outside fetch did not answer next cycle");

  // Results outside the span carry zero pen and position
  a_background: assert property (@(posedge clk) disable iff (rst)
    (done && !inside_res) |-> (pixel == '0 && source_pos == '0))
    else $error("background result not zero");

  // A load transaction produces no result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == pls_pkg::ACT_LOAD) |=> !done)
    else $error("load transaction produced a result");

  // Controller never strobes a result while busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while busy");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 400;
  localparam int CALM_TAIL    = 40;
  localparam int SETTLE       = 12;

  // One transaction toward the scaler
  typedef struct packed {
    logic                           act;
    logic [pls_pkg::INDEX_BITS-1:0] idx;
    logic [pls_pkg::PIXEL_BITS-1:0] pen;
    logic [pls_pkg::X_BITS-1:0]     col;
    logic [pls_pkg::EDGE_BITS-1:0]  left;
    logic [pls_pkg::EDGE_BITS-1:0]  right;
  } scaler_txn_t;

  // One destination pixel as the block should return it
  typedef struct packed {
    logic [pls_pkg::PIXEL_BITS-1:0] pixel;
    logic                           inside_flag;
    logic [pls_pkg::QUOT_BITS-1:0]  pos;
  } dest_pixel_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           action = pls_pkg::ACT_LOAD;
  logic [pls_pkg::INDEX_BITS-1:0] src_index = '0;
  logic [pls_pkg::PIXEL_BITS-1:0] src_value = '0;
  logic [pls_pkg::X_BITS-1:0]     dest_x = '0;
  logic [pls_pkg::EDGE_BITS-1:0]  left_edge = '0;
  logic [pls_pkg::EDGE_BITS-1:0]  right_edge = '0;
  logic                           busy;
  logic                           done;
  logic [pls_pkg::PIXEL_BITS-1:0] pixel;
  logic                           inside_res;
  logic [pls_pkg::QUOT_BITS-1:0]  source_pos;

  scaler_txn_t                    pending_txns[$];
  dest_pixel_t                    expected_pixels[$];
  logic [pls_pkg::PIXEL_BITS-1:0] line_pens[pls_pkg::LINE_WIDTH];
  logic [pls_pkg::LINE_WIDTH-1:0] loaded_mask = '0;
  logic                           took = 1'b0;
  int                             gap_left = 0;
  int                             errors = 0;
  int                             cycles = 0;

  perspective_line_scaler_unit uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .action     (action),
    .src_index  (src_index),
    .src_value  (src_value),
    .dest_x     (dest_x),
    .left_edge  (left_edge),
    .right_edge (right_edge),
    .pixel      (pixel),
    .inside_res (inside_res),
    .source_pos (source_pos)
  );

  always #1 clk = ~clk;

  // Span is [left, 256 + right)
  function automatic bit in_span(int col, int left, int right);
    return col >= left && col < 256 + right;
  endfunction

  // Source position for a column inside the span, rounded down
  function automatic int span_pos(int col, int left, int right);
    return (pls_pkg::LINE_WIDTH * (col - left)) / (256 + right - left);
  endfunction

  function automatic dest_pixel_t scale_column(int col, int left, int right);
    dest_pixel_t res;
    res = '0;
    if (in_span(col, left, right)) begin
      res.pos         = pls_pkg::QUOT_BITS'(span_pos(col, left, right));
      res.pixel       = line_pens[res.pos];
      res.inside_flag = 1'b1;
    end
    return res;
  endfunction

  // Stimulus builders; fetch fields are random on loads and vice versa
  task automatic push_load(int idx, int pen);
    scaler_txn_t t;
    t.act   = pls_pkg::ACT_LOAD;
    t.idx   = pls_pkg::INDEX_BITS'(idx);
    t.pen   = pls_pkg::PIXEL_BITS'(pen);
    t.col   = pls_pkg::X_BITS'($urandom);
    t.left  = pls_pkg::EDGE_BITS'($urandom);
    t.right = pls_pkg::EDGE_BITS'($urandom);
    loaded_mask[t.idx] = 1'b1;
    pending_txns.push_back(t);
  endtask

  // Never sample an entry that has not been loaded: load it first
  task automatic push_fetch(int col, int left, int right);
    scaler_txn_t t;
    int          pos;
    if (in_span(col, left, right)) begin
      pos = span_pos(col, left, right);
      if (!loaded_mask[pos]) push_load(pos, $urandom_range(0, 255));
    end
    t.act   = pls_pkg::ACT_FETCH;
    t.idx   = pls_pkg::INDEX_BITS'($urandom);
    t.pen   = pls_pkg::PIXEL_BITS'($urandom);
    t.col   = pls_pkg::X_BITS'(col);
    t.left  = pls_pkg::EDGE_BITS'(left);
    t.right = pls_pkg::EDGE_BITS'(right);
    pending_txns.push_back(t);
  endtask

  function automatic int pick_edge();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic build_directed();
    push_load(0, 8'hFF);
    push_load(127, 8'hA5);
    push_load(64, 8'h00);
    // Widest and narrowest spans, both ends, just outside each end
    push_fetch(0, 0, 0);
    push_fetch(255, 0, 0);
    push_fetch(256, 0, 0);
    push_fetch(255, 255, 255);
    push_fetch(510, 255, 255);
    push_fetch(511, 255, 255);
    push_fetch(254, 255, 255);
    push_fetch(255, 255, 0);
    push_fetch(256, 255, 0);
    push_fetch(510, 0, 255);
    push_fetch(511, 0, 255);
    push_fetch(0, 1, 0);
    push_fetch(300, 128, 128);
    push_fetch(128, 128, 128);
    push_fetch(383, 128, 128);
  endtask

  task automatic build_random();
    int left, right, n, base;
    while (pending_txns.size() < RANDOM_ITEMS + 25) begin
      if ($urandom_range(0, 9) < 7) begin
        // Line pair: load part of the line, then sweep columns across it
        left  = pick_edge();
        right = pick_edge();
        n     = $urandom_range(2, 16);
        base  = $urandom_range(0, pls_pkg::LINE_WIDTH - 1);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 1)) begin
            push_load((base + i) % pls_pkg::LINE_WIDTH, $urandom_range(0, 255));
          end else begin
            push_load($urandom_range(0, pls_pkg::LINE_WIDTH - 1), $urandom_range(0, 255));
          end
        end
        n = $urandom_range(4, 16);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 4) != 0) push_fetch($urandom_range(left, 255 + right), left, right);
          else push_fetch($urandom_range(0, 511), left, right);
        end
      end else begin
        // Noise: scattered loads and fetches with fully random fields
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 1)) push_load($urandom_range(0, 127), $urandom_range(0, 255));
          else push_fetch($urandom_range(0, 511), $urandom_range(0, 255), $urandom_range(0, 255));
        end
      end
    end
  endtask

  // Driver: hold a transaction until taken, idle in random bursts until the tail
  always @(negedge clk) begin
    scaler_txn_t t;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending_txns.size() == 0) begin
      start <= 1'b0;
    end else if (pending_txns.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      gap_left = $urandom_range(0, 5);
    end else begin
      t = pending_txns.pop_front();
      action     <= t.act;
      src_index  <= t.idx;
      src_value  <= t.pen;
      dest_x     <= t.col;
      left_edge  <= t.left;
      right_edge <= t.right;
      start      <= 1'b1;
    end
  end

  // Monitor: check results, then predict for a transaction taken at this edge
  always @(posedge clk) begin
    dest_pixel_t want;
    took = !rst && start && !busy;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $error("result with none pending: pixel %0d inside %0d pos %0d",
               pixel, inside_res, source_pos);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (pixel !== want.pixel) begin
          $error("pixel: expected %0d, got %0d", want.pixel, pixel);
          errors++;
        end
        if (inside_res !== want.inside_flag) begin
          $error("inside_res: expected %0d, got %0d", want.inside_flag, inside_res);
          errors++;
        end
        if (source_pos !== want.pos) begin
          $error("source_pos: expected %0d, got %0d", want.pos, source_pos);
          errors++;
        end
      end
    end
    if (took) begin
      if (action == pls_pkg::ACT_LOAD) line_pens[src_index] = src_value;
      else expected_pixels.push_back(scale_column(dest_x, left_edge, right_edge));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Drain: everything sent, taken and answered
    while (pending_txns.size() != 0 || start || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
